/* sv/keypad_scan_debounce_multitap_assert.svh */
// ----------------------------------------------------------------------------
// Keypad scanner assertion macros
// Shared assertion forms for the keypad scanner, clocked on clk and
// disabled during rst.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_SCAN_DEBOUNCE_MULTITAP_ASSERT_SVH
`define KEYPAD_SCAN_DEBOUNCE_MULTITAP_ASSERT_SVH

// Same-cycle implication: whenever ante holds, cons must hold too.
`define KSDM_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("keypad scanner: same-cycle check failed");

// Next-cycle implication: whenever ante holds, cons must hold in the following cycle.
`define KSDM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("keypad scanner: next-cycle check failed");

`endif

/* sv/ksdm_pkg.sv */
// ----------------------------------------------------------------------------
// ksdm_pkg
// Types, constants and key tables for the 4x3 keypad scanner with debounce
// and multi-tap letter selection.
// ----------------------------------------------------------------------------
package ksdm_pkg;

  // Configuration register indexes, reset values and counter/column constants.
  localparam logic       CFG_BOUNCE     = 1'b0;
  localparam logic       CFG_MULTITAP   = 1'b1;
  localparam logic [15:0] BOUNCE_RESET   = 16'd15;
  localparam logic [15:0] MULTITAP_RESET = 16'd1000;
  localparam logic [15:0] COUNT_SAT      = 16'hFFFF;
  localparam logic [2:0]  COLS_IDLE      = 3'b111;

  // Debounce state machine, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_PRESS   = 4'b0010,
    ST_HOLD    = 4'b0100,
    ST_RELEASE = 4'b1000
  } state_t;

  // One result beat.
  typedef struct packed {
    logic [3:0] row_drive;
    logic       key_valid;
    logic [7:0] key_char;
  } result_t;

  // Letter string of a key, last letter in the low byte.
  typedef logic [39:0] key_str_t;

  // Number of letters on the key at (row, col).
  function automatic logic [2:0] key_count(input logic [1:0] row, input logic [1:0] col);
    logic [2:0] n;
    n = 3'd1;
    unique case ({row, col})
      4'b00_01, 4'b00_10: n = 3'd4;
      4'b01_00, 4'b01_01, 4'b01_10: n = 3'd4;
      4'b10_00, 4'b10_10: n = 3'd5;
      4'b10_01: n = 3'd4;
      default: n = 3'd1;
    endcase
    return n;
  endfunction

  // Letter string of the key at (row, col).
  function automatic key_str_t key_string(input logic [1:0] row, input logic [1:0] col);
    key_str_t s;
    s = key_str_t'("1");
    unique case ({row, col})
      4'b00_00: s = key_str_t'("1");
      4'b00_01: s = key_str_t'("ABC2");
      4'b00_10: s = key_str_t'("DEF3");
      4'b01_00: s = key_str_t'("GHI4");
      4'b01_01: s = key_str_t'("JKL5");
      4'b01_10: s = key_str_t'("MNO6");
      4'b10_00: s = key_str_t'("PQRS7");
      4'b10_01: s = key_str_t'("TUV8");
      4'b10_10: s = key_str_t'("WXYZ9");
      4'b11_00: s = key_str_t'("*");
      4'b11_01: s = key_str_t'("0");
      4'b11_10: s = key_str_t'("#");
      default:  s = key_str_t'("#");
    endcase
    return s;
  endfunction

  // Letter number idx of the key; idx is below the key's letter count.
  function automatic logic [7:0] key_letter(input logic [1:0] row, input logic [1:0] col,
                                            input logic [2:0] idx);
    key_str_t   s;
    logic [2:0] pos;
    s   = key_string(row, col);
    pos = key_count(row, col) - 3'd1 - idx;
    return s[{pos, 3'b000} +: 8];
  endfunction

endpackage

/* sv/keypad_scan_debounce_multitap.sv */
// ----------------------------------------------------------------------------
// keypad_scan_debounce_multitap
// 4x3 matrix keypad scanner with press/release debounce and multi-tap letters.
// ----------------------------------------------------------------------------
// Each input beat is one scan tick carrying the sampled active-low column
// lines (col_lines). Each tick yields exactly one result beat: the active-low
// row drive that applied during that tick, plus key_valid/key_char when a
// debounced release completes a key (key_char is zero otherwise).
// The block takes one tick per cycle while in_ready is high; its result goes
// to the result or skid register. The state update is one short step of
// logic between the input handshake and the result register.
// A two-entry output stage (result register plus skid register) lets a tick
// be accepted while a result waits; in_ready drops only when both are full,
// i.e. after the receiver has held out_ready low with a result pending and
// another tick has been accepted. No beat is lost or repeated under stalls.
// Configuration: cfg_write with cfg_index 0 sets bounce_ticks, index 1 sets
// multitap_ticks; write only while no tick is in flight.
// Reset (synchronous, rst high) returns to idle at row 0, clears the letter
// index, saturates the gap counter and loads bounce_ticks 15 and
// multitap_ticks 1000. Output and skid registers are emptied.
// ----------------------------------------------------------------------------
`include "keypad_scan_debounce_multitap_assert.svh"

module keypad_scan_debounce_multitap (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  col_lines,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  row_drive,
  output logic        key_valid,
  output logic [7:0]  key_char,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import ksdm_pkg::*;

  // Configuration registers.
  logic [15:0] bounce_ticks;
  logic [15:0] multitap_ticks;

  // Scanner state.
  state_t      state, state_next;
  logic [1:0]  scan_row, scan_row_next;
  logic [1:0]  pressed_row, pressed_row_next;
  logic [1:0]  pressed_col, pressed_col_next;
  logic [1:0]  prev_row, prev_row_next;
  logic [1:0]  prev_col, prev_col_next;
  logic [2:0]  letter_index, letter_index_next;
  logic [15:0] debounce_count, debounce_count_next;
  logic [15:0] gap_count, gap_count_next;

  // Output stage.
  result_t     result_next;
  result_t     out_data, skid_data;
  logic        skid_valid;

  logic        accept, take;
  logic        pressed;
  logic [1:0]  row, hit_col, key_col;
  logic [15:0] debounce_inc;
  logic [2:0]  index_inc;

  assign accept   = in_valid && in_ready;
  assign take     = out_valid && out_ready;
  assign in_ready = !skid_valid;

  assign row_drive = out_data.row_drive;
  assign key_valid = out_data.key_valid;
  assign key_char  = out_data.key_char;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      bounce_ticks   <= BOUNCE_RESET;
      multitap_ticks <= MULTITAP_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BOUNCE:   bounce_ticks   <= cfg_data;
        CFG_MULTITAP: multitap_ticks <= cfg_data;
        default:      bounce_ticks   <= bounce_ticks;
      endcase
    end
  end

  // Tick decode: row, highest low column, saturating debounce step, index step.
  always_comb begin
    pressed      = col_lines != COLS_IDLE;
    row          = (state == ST_IDLE) ? scan_row : pressed_row;
    hit_col      = 2'd0;
    if (!col_lines[1]) hit_col = 2'd1;
    if (!col_lines[2]) hit_col = 2'd2;
    key_col      = (pressed_col > 2'd2) ? 2'd2 : pressed_col;
    debounce_inc = (debounce_count == COUNT_SAT) ? COUNT_SAT : debounce_count + 16'd1;
    index_inc    = letter_index + 3'd1;
  end

  // Debounce state machine and multi-tap selection for one tick.
  always_comb begin
    state_next          = state;
    scan_row_next       = scan_row;
    pressed_row_next    = pressed_row;
    pressed_col_next    = pressed_col;
    prev_row_next       = prev_row;
    prev_col_next       = prev_col;
    letter_index_next   = letter_index;
    debounce_count_next = debounce_count;
    gap_count_next      = (gap_count == COUNT_SAT) ? COUNT_SAT : gap_count + 16'd1;
    result_next.row_drive = ~(4'b0001 << row);
    result_next.key_valid = 1'b0;
    result_next.key_char  = 8'd0;

    unique case (state)
      ST_IDLE: begin
        if (pressed) begin
          pressed_row_next    = row;
          pressed_col_next    = hit_col;
          debounce_count_next = 16'd0;
          state_next          = ST_PRESS;
        end else begin
          scan_row_next = scan_row + 2'd1;
        end
      end
      ST_PRESS: begin
        if (!pressed) begin
          state_next = ST_IDLE;
        end else begin
          debounce_count_next = debounce_inc;
          if (debounce_inc >= bounce_ticks) state_next = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (!pressed) begin
          debounce_count_next = 16'd0;
          state_next          = ST_RELEASE;
        end
      end
      ST_RELEASE: begin
        if (pressed) begin
          state_next = ST_HOLD;
        end else begin
          debounce_count_next = debounce_inc;
          if (debounce_inc >= bounce_ticks) begin
            // Same key within the multi-tap window steps to the next letter.
            if (gap_count < multitap_ticks && pressed_row == prev_row &&
                key_col == prev_col) begin
              letter_index_next = (index_inc >= key_count(pressed_row, key_col)) ?
                                  3'd0 : index_inc;
            end else begin
              letter_index_next = 3'd0;
            end
            prev_row_next         = pressed_row;
            prev_col_next         = key_col;
            result_next.key_valid = 1'b1;
            result_next.key_char  = key_letter(pressed_row, key_col, letter_index_next);
            gap_count_next        = 16'd0;
            state_next            = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State registers advance once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      scan_row       <= 2'd0;
      pressed_row    <= 2'd0;
      pressed_col    <= 2'd0;
      prev_row       <= 2'd0;
      prev_col       <= 2'd0;
      letter_index   <= 3'd0;
      debounce_count <= 16'd0;
      gap_count      <= COUNT_SAT;
    end else if (accept) begin
      state          <= state_next;
      scan_row       <= scan_row_next;
      pressed_row    <= pressed_row_next;
      pressed_col    <= pressed_col_next;
      prev_row       <= prev_row_next;
      prev_col       <= prev_col_next;
      letter_index   <= letter_index_next;
      debounce_count <= debounce_count_next;
      gap_count      <= gap_count_next;
    end
  end

  // Result register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (take) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept;
        if (accept) out_data <= result_next;
      end
    end else if (accept) begin
      if (out_valid) begin
        skid_data  <= result_next;
        skid_valid <= 1'b1;
      end else begin
        out_data  <= result_next;
        out_valid <= 1'b1;
      end
    end
  end

  // The skid entry is only ever filled behind a waiting result.
  `KSDM_ASSERT_IMPL(a_skid_behind_out, skid_valid, out_valid)
  // Exactly one row line is driven low in every result.
  `KSDM_ASSERT_IMPL(a_one_row_low, out_valid, $countones(row_drive) == 3)
  // A result without a key carries a zero character; a key carries a nonzero one.
  `KSDM_ASSERT_IMPL(a_char_matches_valid, out_valid, (key_char != 8'd0) == key_valid)
  // The letter index always stays within the last accepted key's string.
  `KSDM_ASSERT_NEXT(a_index_in_range, accept,
                    letter_index < key_count(prev_row, prev_col))

endmodule
